// File: rtl/core/mbpq_pkg.sv
// Package with the sizes, codes and control structs of the bucket priority queue.
`timescale 1ns / 1ps

package mbpq_pkg;

  localparam int NUM_PRIORITIES = 256;
  localparam int NUM_VALUES     = 1024;
  localparam int PRI_W          = $clog2(NUM_PRIORITIES);
  localparam int VAL_W          = $clog2(NUM_VALUES);
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 1;

  localparam logic [PRI_W-1:0] PRI_LAST = PRI_W'(NUM_PRIORITIES - 1);
  localparam logic [VAL_W-1:0] VAL_LAST = VAL_W'(NUM_VALUES - 1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFO     = 1'b1;

  typedef struct packed {
    logic load_item;
    logic clr_wr;
    logic seek_step;
    logic bkt_rd_cur;
    logic bkt_rd_pri;
    logic node_rd_head;
    logic add_first;
    logic add_lifo;
    logic add_fifo;
    logic add_tail;
    logic rem_commit;
    logic rem_empty;
  } mbpq_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic item_nonempty;
    logic cur_nonempty;
    logic cur_at_end;
    logic out_busy;
    logic lifo;
  } mbpq_sts_t;

endpackage

// File: rtl/core/mbpq_if.sv
// Valid/ready channel interfaces for the queue's input and result streams.
`timescale 1ns / 1ps

interface mbpq_in_if
  import mbpq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PRI_W-1:0] priority_req;
  logic [VAL_W-1:0] value;

  modport source (output valid, output cmd, output priority_req, output value, input ready);
  modport sink (input valid, input cmd, input priority_req, input value, output ready);
endinterface

interface mbpq_out_if
  import mbpq_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] out_value;
  logic             empty_res;

  modport source (output valid, output out_value, output empty_res, input ready);
  modport sink (input valid, input out_value, input empty_res, output ready);
endinterface

// File: rtl/core/mbpq_datapath.sv
// Datapath of the bucket queue: bucket and node memories, cursor and result register.
`timescale 1ns / 1ps

module mbpq_datapath
  import mbpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PRI_W-1:0]      in_pri,
  input  logic [VAL_W-1:0]      in_val,
  input  logic                  out_ready,
  input  mbpq_cmd_t             cmd,
  output mbpq_sts_t             sts,
  output logic                  out_valid,
  output logic [VAL_W-1:0]      out_value,
  output logic                  empty_res
);

  logic [2*VAL_W-1:0] bkt_mem_r [NUM_PRIORITIES];
  logic [VAL_W:0]     node_mem_r [NUM_VALUES];

  logic [NUM_PRIORITIES-1:0] nonempty_r, nonempty_nxt;
  logic [PRI_W-1:0]          cursor_r, cursor_nxt;
  logic                      maximize_r, maximize_nxt;
  logic                      lifo_r, lifo_nxt;
  logic [VAL_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [PRI_W-1:0]          item_pri_r;
  logic [VAL_W-1:0]          item_val_r;
  logic [2*VAL_W-1:0]        bkt_rd_r;
  logic [VAL_W:0]            node_rd_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]          out_value_r;
  logic                      empty_res_r;

  logic [VAL_W-1:0] head_rd, tail_rd, next_rd;
  logic             has_next_rd;

  logic               bkt_we;
  logic [PRI_W-1:0]   bkt_wa;
  logic [2*VAL_W-1:0] bkt_wd;
  logic [PRI_W-1:0]   bkt_ra;
  logic               node_we;
  logic [VAL_W-1:0]   node_wa;
  logic [VAL_W:0]     node_wd;

  assign head_rd     = bkt_rd_r[2*VAL_W-1:VAL_W];
  assign tail_rd     = bkt_rd_r[VAL_W-1:0];
  assign has_next_rd = node_rd_r[VAL_W];
  assign next_rd     = node_rd_r[VAL_W-1:0];

  always_comb begin
    bkt_we = 1'b0;
    bkt_wa = item_pri_r;
    bkt_wd = {head_rd, item_val_r};
    if (cmd.add_first) begin
      bkt_we = 1'b1;
      bkt_wd = {item_val_r, item_val_r};
    end else if (cmd.add_lifo) begin
      bkt_we = 1'b1;
      bkt_wd = {item_val_r, tail_rd};
    end else if (cmd.add_fifo) begin
      bkt_we = 1'b1;
      bkt_wd = {head_rd, item_val_r};
    end else if (cmd.rem_commit && has_next_rd) begin
      bkt_we = 1'b1;
      bkt_wa = cursor_r;
      bkt_wd = {next_rd, tail_rd};
    end
  end

  always_comb begin
    node_we = 1'b0;
    node_wa = item_val_r;
    node_wd = '0;
    if (cmd.clr_wr) begin
      node_we = 1'b1;
      node_wa = clr_cnt_r;
    end else if (cmd.add_first || cmd.add_fifo) begin
      node_we = 1'b1;
    end else if (cmd.add_lifo) begin
      node_we = 1'b1;
      node_wd = {1'b1, head_rd};
    end else if (cmd.add_tail) begin
      node_we = 1'b1;
      node_wa = tail_rd;
      node_wd = {1'b1, item_val_r};
    end else if (cmd.rem_commit) begin
      node_we = 1'b1;
      node_wa = head_rd;
      node_wd = {1'b0, next_rd};
    end
  end

  assign bkt_ra = cmd.bkt_rd_cur ? cursor_r : item_pri_r;

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem_r[bkt_wa] <= bkt_wd;
    end
    if (cmd.bkt_rd_cur || cmd.bkt_rd_pri) begin
      bkt_rd_r <= bkt_mem_r[bkt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem_r[node_wa] <= node_wd;
    end
    if (cmd.node_rd_head) begin
      node_rd_r <= node_mem_r[head_rd];
    end
  end

  always_comb begin
    maximize_nxt = maximize_r;
    lifo_nxt     = lifo_r;
    cursor_nxt   = cursor_r;
    if (cmd.seek_step) begin
      cursor_nxt = maximize_r ? cursor_r - 1'b1 : cursor_r + 1'b1;
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAXIMIZE: begin
          maximize_nxt = cfg_data[0];
          cursor_nxt   = cfg_data[0] ? PRI_LAST : '0;
        end
        REG_LIFO: begin
          lifo_nxt = cfg_data[0];
        end
        default: begin
          lifo_nxt = lifo_r;
        end
      endcase
    end
  end

  always_comb begin
    nonempty_nxt = nonempty_r;
    if (cmd.add_first) begin
      nonempty_nxt[item_pri_r] = 1'b1;
    end
    if (cmd.rem_commit && !has_next_rd) begin
      nonempty_nxt[cursor_r] = 1'b0;
    end
  end

  assign clr_cnt_nxt   = cmd.clr_wr ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign out_valid_nxt = (cmd.rem_commit || cmd.rem_empty) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= '0;
      cursor_r    <= '0;
      maximize_r  <= 1'b0;
      lifo_r      <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      nonempty_r  <= nonempty_nxt;
      cursor_r    <= cursor_nxt;
      maximize_r  <= maximize_nxt;
      lifo_r      <= lifo_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_pri_r <= in_pri;
      item_val_r <= in_val;
    end
    if (cmd.rem_commit) begin
      out_value_r <= head_rd;
      empty_res_r <= 1'b0;
    end else if (cmd.rem_empty) begin
      out_value_r <= '0;
      empty_res_r <= 1'b1;
    end
  end

  assign sts.clr_done      = (clr_cnt_r == VAL_LAST);
  assign sts.item_nonempty = nonempty_r[item_pri_r];
  assign sts.cur_nonempty  = nonempty_r[cursor_r];
  assign sts.cur_at_end    = maximize_r ? (cursor_r == '0) : (cursor_r == PRI_LAST);
  assign sts.out_busy      = out_valid_r && !out_ready;
  assign sts.lifo          = lifo_r;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign empty_res = empty_res_r;

endmodule

// File: rtl/core/mbpq_ctrl.sv
// Controller state machine that sequences the reset clear and the add, seek and remove operations.
`timescale 1ns / 1ps

module mbpq_ctrl
  import mbpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  input  mbpq_sts_t sts,
  output mbpq_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_ADD_RD   = 8'b0000_0100,
    ST_ADD_WR   = 8'b0000_1000,
    ST_ADD_TAIL = 8'b0001_0000,
    ST_SEEK     = 8'b0010_0000,
    ST_REM_NODE = 8'b0100_0000,
    ST_REM_UPD  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = (in_cmd == CMD_REMOVE) ? ST_SEEK : ST_ADD_RD;
        end
      end
      ST_ADD_RD: begin
        if (!sts.item_nonempty) begin
          cmd.add_first = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.bkt_rd_pri = 1'b1;
          state_nxt      = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        if (sts.lifo) begin
          cmd.add_lifo = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.add_fifo = 1'b1;
          state_nxt    = ST_ADD_TAIL;
        end
      end
      ST_ADD_TAIL: begin
        cmd.add_tail = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_SEEK: begin
        if (sts.cur_nonempty) begin
          cmd.bkt_rd_cur = 1'b1;
          state_nxt      = ST_REM_NODE;
        end else if (sts.cur_at_end) begin
          if (!sts.out_busy) begin
            cmd.rem_empty = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.seek_step = 1'b1;
        end
      end
      ST_REM_NODE: begin
        cmd.node_rd_head = 1'b1;
        state_nxt        = ST_REM_UPD;
      end
      ST_REM_UPD: begin
        if (!sts.out_busy) begin
          cmd.rem_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_one_node_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.clr_wr, cmd.add_first, cmd.add_lifo, cmd.add_fifo,
                cmd.add_tail, cmd.rem_commit}) <= 1)
    else $error("more than one node memory write in a cycle");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rem_commit || cmd.rem_empty) |-> !sts.out_busy)
    else $error("result loaded while the previous one is still pending");

  a_empty_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_empty |-> (sts.cur_at_end && !sts.cur_nonempty))
    else $error("empty result reported before the scan reached the end");

  a_commit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_commit |-> ($past(cmd.node_rd_head) || $past(state_r) == ST_REM_UPD))
    else $error("remove committed without a node read");
`endif

endmodule

// File: rtl/core/monotone_bucket_priority_queue_unit.sv
// Top level of the monotone bucket priority queue: controller plus datapath.
//
//   channel  direction  transfer fields
//   in_ch    sink       cmd, priority_req, value
//   out_ch   source     out_value, empty_res (one per remove, none per add)
//   cfg_*    write      cfg_index selects maximize_mode (0) or lifo_policy (1)
//
// After reset the node memory is cleared entry by entry; in_ch.ready stays low meanwhile.
// An add to an empty bucket writes it at once; else the bucket is read, then relinked
// (under FIFO its old tail is linked last). A remove scans buckets, then reads the head.
// The next item is taken while a result waits in the output register.
// A remove that finishes while that register is still full waits for out_ch.ready.
`timescale 1ns / 1ps

module monotone_bucket_priority_queue_unit
  import mbpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mbpq_in_if.sink               in_ch,
  mbpq_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mbpq_cmd_t cmd;
  mbpq_sts_t sts;

  mbpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbpq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pri    (in_ch.priority_req),
    .in_val    (in_ch.value),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_value (out_ch.out_value),
    .empty_res (out_ch.empty_res)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the monotone bucket priority queue unit.
`timescale 1ns / 1ps

module tb_top;
  import mbpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          ADD_SETTLE   = 16;
  localparam int          DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             empty;
  } pop_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbpq_in_if  in_ch();
  mbpq_out_if out_ch();

  monotone_bucket_priority_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit [VAL_W-1:0] bkt_head [NUM_PRIORITIES];
  bit [VAL_W-1:0] bkt_tail [NUM_PRIORITIES];
  bit             bkt_nonempty [NUM_PRIORITIES];
  bit [VAL_W-1:0] node_next [NUM_VALUES];
  bit             node_has_next [NUM_VALUES];
  bit             node_in_use [NUM_VALUES];
  bit [PRI_W-1:0] mdl_cursor;
  bit             mdl_maximize;
  bit             mdl_lifo;

  pop_result_t expected_pops[$];

  int n_items;
  int n_adds;
  int n_removes;
  int n_empty;
  int n_checked;
  int n_cfg_writes;
  int failures;

  bit no_idle;
  bit steady_send;
  int hold_request;
  int hold_len;

  function automatic logic seek_nonempty();
    while (!bkt_nonempty[mdl_cursor]) begin
      if (mdl_maximize) begin
        if (mdl_cursor == '0) return 1'b0;
        mdl_cursor--;
      end else begin
        if (mdl_cursor == PRI_LAST) return 1'b0;
        mdl_cursor++;
      end
    end
    return 1'b1;
  endfunction

  function automatic void apply_queue_cmd(logic cmd, logic [PRI_W-1:0] pri,
                                          logic [VAL_W-1:0] val);
    pop_result_t      res;
    logic [VAL_W-1:0] v;
    n_items++;
    if (cmd == CMD_ADD) begin
      n_adds++;
      node_in_use[val] = 1'b1;
      if (!bkt_nonempty[pri]) begin
        bkt_head[pri]      = val;
        bkt_tail[pri]      = val;
        bkt_nonempty[pri]  = 1'b1;
        node_has_next[val] = 1'b0;
        node_next[val]     = '0;
      end else if (mdl_lifo) begin
        node_next[val]     = bkt_head[pri];
        node_has_next[val] = 1'b1;
        bkt_head[pri]      = val;
      end else begin
        v                  = bkt_tail[pri];
        node_has_next[val] = 1'b0;
        node_next[val]     = '0;
        node_next[v]       = val;
        node_has_next[v]   = 1'b1;
        bkt_tail[pri]      = val;
      end
      return;
    end
    n_removes++;
    if (!seek_nonempty()) begin
      res.value = '0;
      res.empty = 1'b1;
      n_empty++;
    end else begin
      v = bkt_head[mdl_cursor];
      if (node_has_next[v]) bkt_head[mdl_cursor] = node_next[v];
      else bkt_nonempty[mdl_cursor] = 1'b0;
      node_has_next[v] = 1'b0;
      node_in_use[v]   = 1'b0;
      res.value = v;
      res.empty = 1'b0;
    end
    expected_pops.push_back(res);
  endfunction

  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 5))
      0: return PRI_W'($urandom);
      1: return PRI_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                            : $urandom_range(NUM_PRIORITIES - 2,
                                                             NUM_PRIORITIES - 1));
      default: return mdl_maximize ? PRI_W'($urandom_range(0, mdl_cursor))
                                   : PRI_W'($urandom_range(mdl_cursor, PRI_LAST));
    endcase
  endfunction

  function automatic logic [PRI_W-1:0] near_priority(logic [PRI_W-1:0] base, int spread);
    int p;
    p = mdl_maximize ? int'(base) - $urandom_range(0, spread)
                     : int'(base) + $urandom_range(0, spread);
    if (p < 0) p = 0;
    if (p > NUM_PRIORITIES - 1) p = NUM_PRIORITIES - 1;
    return PRI_W'(p);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    v = VAL_W'($urandom);
    if ($urandom_range(0, 19) == 0) return v;
    for (int i = 0; i < 8 && node_in_use[v]; i++) v = VAL_W'($urandom);
    return v;
  endfunction

  task automatic send_item(input logic cmd, input logic [PRI_W-1:0] pri,
                           input logic [VAL_W-1:0] val);
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd;
    in_ch.priority_req <= pri;
    in_ch.value        <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_queue_cmd(cmd, pri, val);
    if (!no_idle && !steady_send && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_remove();
    send_item(CMD_REMOVE, PRI_W'($urandom), VAL_W'($urandom));
  endtask

  // An add leaves no result behind, so allow the last one to retire before going on.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (ADD_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    n_cfg_writes++;
    if (idx == REG_MAXIMIZE) begin
      mdl_maximize = data[0];
      mdl_cursor   = data[0] ? PRI_LAST : '0;
    end else if (idx == REG_LIFO) begin
      mdl_lifo = data[0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_mixed_traffic(input int n_target);
    int               start;
    int               nadd;
    int               spread;
    logic [PRI_W-1:0] base;
    start = n_items;
    while (n_items - start < n_target) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          repeat ($urandom_range(1, 6))
            send_item($urandom_range(0, 1) ? CMD_REMOVE : CMD_ADD,
                      PRI_W'($urandom), pick_value());
        end
        9: begin
          repeat ($urandom_range(1, 20)) send_remove();
        end
        default: begin
          nadd   = $urandom_range(1, 12);
          base   = pick_priority();
          spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          repeat (nadd) send_item(CMD_ADD, near_priority(base, spread), pick_value());
          repeat ($urandom_range(1, nadd + 2)) send_remove();
        end
      endcase
    end
  endtask

  task automatic test_min_fifo_extremes();
    send_item(CMD_ADD, 8'd0, 10'd0);
    send_item(CMD_ADD, PRI_LAST, VAL_LAST);
    send_item(CMD_ADD, 8'd0, 10'd5);
    send_item(CMD_ADD, 8'd0, 10'd512);
    repeat (4) send_remove();
    send_remove();
    send_item(CMD_ADD, 8'd10, 10'd7);
    send_item(CMD_ADD, PRI_LAST, 10'd9);
    repeat (2) send_remove();
  endtask

  task automatic test_max_lifo_relink();
    write_reg(REG_MAXIMIZE, 1'b1);
    write_reg(REG_LIFO, 1'b1);
    send_remove();
    send_item(CMD_ADD, 8'd10, 10'd3);
    send_item(CMD_ADD, 8'd10, 10'd4);
    repeat (2) send_remove();
    send_item(CMD_ADD, 8'd2, 10'd8);
    send_item(CMD_ADD, 8'd2, 10'd8);
    repeat (3) send_remove();
    send_item(CMD_ADD, 8'd0, VAL_LAST);
    send_item(CMD_ADD, 8'd200, 10'd6);
    repeat (2) send_remove();
    write_reg(REG_MAXIMIZE, 1'b1);
    send_remove();
  endtask

  task automatic test_mode_sweep();
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(REG_MAXIMIZE, (phase < 4) ? CFG_DATA_W'(phase[1]) : CFG_DATA_W'($urandom));
      write_reg(REG_LIFO, (phase < 4) ? CFG_DATA_W'(~phase[0]) : CFG_DATA_W'($urandom));
      run_mixed_traffic(80);
    end
  endtask

  task automatic test_output_backpressure();
    write_reg(REG_MAXIMIZE, 1'b0);
    steady_send  = 1'b1;
    hold_len     = 300;
    hold_request = hold_request + 1;
    repeat (15) send_item(CMD_ADD, pick_priority(), pick_value());
    repeat (30) send_remove();
    steady_send = 1'b0;
  endtask

  task automatic test_steady_tail();
    write_reg(REG_LIFO, CFG_DATA_W'($urandom));
    no_idle = 1'b1;
    run_mixed_traffic(50);
  endtask

  initial begin : result_sink
    int hold_granted;
    int hold_left;
    int stall_left;
    hold_granted = 0;
    hold_left    = 0;
    stall_left   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_granted != hold_request) begin
        hold_granted = hold_request;
        hold_left    = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    pop_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pops.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result transfer: value %0d empty %0d",
                   out_ch.out_value, out_ch.empty_res);
      end else begin
        want = expected_pops.pop_front();
        n_checked++;
        if (out_ch.out_value !== want.value || out_ch.empty_res !== want.empty) begin
          failures++;
          if (failures <= 10)
            $display("result mismatch: expected value %0d empty %0d, got value %0d empty %0d",
                     want.value, want.empty, out_ch.out_value, out_ch.empty_res);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[monotone_bucket_priority_queue_unit] ERROR");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_ADD;
    in_ch.priority_req <= '0;
    in_ch.value        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_min_fifo_extremes();
    test_max_lifo_relink();
    test_mode_sweep();
    test_output_backpressure();
    test_steady_tail();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d items: %0d adds, %0d removes (%0d found the queue empty).",
             n_items, n_adds, n_removes, n_empty);
    $display("Checked %0d results across %0d register writes; %0d failures.",
             n_checked, n_cfg_writes, failures);
    if (failures == 0 && expected_pops.size() == 0)
      $display("[monotone_bucket_priority_queue_unit] OK");
    else
      $display("[monotone_bucket_priority_queue_unit] ERROR");
    $finish;
  end

endmodule

// File: monotone_bucket_priority_queue_unit.f
rtl/core/mbpq_pkg.sv
rtl/core/mbpq_if.sv
rtl/core/mbpq_datapath.sv
rtl/core/mbpq_ctrl.sv
rtl/core/monotone_bucket_priority_queue_unit.sv
tb/tb_top.sv
